[sv/ppq_pkg.sv]
// shared types and constants of the priority process queue
package ppq_pkg;

   // default sizes
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_PRIO_BITS   = 8;

   // field widths fixed by the request and response ports
   localparam int ID_BITS        = 4;
   localparam int PORT_PRIO_BITS = 8;

   // request codes
   typedef enum logic [1:0] {
      REQ_INSERT      = 2'd0,
      REQ_REMOVE_HEAD = 2'd1,
      REQ_REMOVE_ID   = 2'd2,
      REQ_PEEK_HEAD   = 2'd3
   } ppq_req_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } ppq_status_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_POP,
      CMD_REMOVE
   } ppq_cmd_type;

   // control group from the top level to the cells
   typedef struct packed {
      ppq_cmd_type        cmd;
      logic [ID_BITS-1:0] id;
   } ppq_ctl_type;

endpackage

[sv/ppq_cell.sv]
// one slot of the sorted queue chain: holds an entry and trades it with its neighbors
module ppq_cell #(
   parameter int PRIO_BITS = ppq_pkg::DEFAULT_PRIO_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ppq_pkg::ppq_ctl_type        ctl,
   input  logic [PRIO_BITS-1:0]        new_prio,
   input  logic                        left_keep,
   input  logic                        left_valid,
   input  logic [ppq_pkg::ID_BITS-1:0] left_id,
   input  logic [PRIO_BITS-1:0]        left_prio,
   input  logic                        right_valid,
   input  logic [ppq_pkg::ID_BITS-1:0] right_id,
   input  logic [PRIO_BITS-1:0]        right_prio,
   input  logic                        hit_in,
   output logic                        valid,
   output logic [ppq_pkg::ID_BITS-1:0] id,
   output logic [PRIO_BITS-1:0]        prio,
   output logic                        keep,
   output logic                        match,
   output logic                        hit_out
);
   import ppq_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [PRIO_BITS-1:0] prio_ff, prio_in;

   // entry stays put on insert when it ranks at or above the new one
   assign keep    = valid_ff && (prio_ff >= new_prio);
   assign match   = valid_ff && (id_ff == ctl.id);
   assign hit_out = hit_in || match;

   assign valid = valid_ff;
   assign id    = id_ff;
   assign prio  = prio_ff;

   // next slot contents
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      prio_in  = prio_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  valid_in = 1'b1;
                  id_in    = ctl.id;
                  prio_in  = new_prio;
               end else begin
                  valid_in = left_valid;
                  id_in    = left_id;
                  prio_in  = left_prio;
               end
            end
         end
         CMD_POP: begin
            valid_in = right_valid;
            id_in    = right_id;
            prio_in  = right_prio;
         end
         CMD_REMOVE: begin
            // close the gap left by the frontmost matching entry
            if (hit_in || match) begin
               valid_in = right_valid;
               id_in    = right_id;
               prio_in  = right_prio;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

endmodule

[sv/priority_process_queue_core.sv]
// priority process queue: a sorted chain of slot cells with a registered response
//
// Request channel: a request (req_type, req_proc_id, req_prio) is taken at every
// rising edge where start is high and busy is low. busy stays low: each request
// is finished in the cycle it is taken, so a request can be issued every cycle.
// Request types: insert, remove head, remove a given id, peek head.
// Response channel: exactly one response per request, shown on the rsp_ ports
// for one cycle with rsp_valid high, in the cycle after the request is taken.
// The receiver cannot stall; a response not sampled in that cycle is gone.
// Throughput: 1 request per cycle, set by the slot cells, which all compare
// against the request and shift toward their neighbor in the same cycle.
// The queue keeps entries sorted by priority, highest first; equal priorities
// leave in arrival order. Status tells ok, miss (empty or id absent) or full.
// Reset (synchronous, active high) empties the queue and drops any response
// in flight; slot payload is not cleared, only the occupancy flags.
module priority_process_queue_core #(
   parameter int QUEUE_DEPTH = ppq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PRIO_BITS   = ppq_pkg::DEFAULT_PRIO_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [ppq_pkg::ID_BITS-1:0]       req_proc_id,
   input  logic [ppq_pkg::PORT_PRIO_BITS-1:0] req_prio,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [ppq_pkg::ID_BITS-1:0]       rsp_out_id,
   output logic [ppq_pkg::PORT_PRIO_BITS-1:0] rsp_out_prio,
   output logic                              rsp_is_empty
);
   import ppq_pkg::*;

   logic                 accept;
   logic [PRIO_BITS-1:0] new_prio;
   ppq_ctl_type          ctl;

   logic                 cell_valid [QUEUE_DEPTH];
   logic [ID_BITS-1:0]   cell_id    [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0] cell_prio  [QUEUE_DEPTH];
   logic                 cell_keep  [QUEUE_DEPTH];
   logic                 cell_match [QUEUE_DEPTH];
   logic                 hit        [QUEUE_DEPTH+1];

   logic                 queue_full, queue_empty;
   logic [ID_BITS-1:0]   found_id;
   logic [PRIO_BITS-1:0] found_prio;

   ppq_status_type       status_in;
   logic [ID_BITS-1:0]   out_id_in;
   logic [PRIO_BITS-1:0] out_prio_in;
   logic                 is_empty_in;

   logic                      rsp_valid_ff;
   ppq_status_type            status_ff;
   logic [ID_BITS-1:0]        out_id_ff;
   logic [PORT_PRIO_BITS-1:0] out_prio_ff;
   logic                      is_empty_ff;

   // every request completes in the cycle it is taken
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign new_prio    = PRIO_BITS'(req_prio);
   assign queue_full  = cell_valid[QUEUE_DEPTH-1];
   assign queue_empty = !cell_valid[0];

   // command to the chain
   always_comb begin
      ctl.id  = req_proc_id;
      ctl.cmd = CMD_HOLD;
      if (accept) begin
         case (req_type)
            REQ_INSERT:      ctl.cmd = queue_full ? CMD_HOLD : CMD_INSERT;
            REQ_REMOVE_HEAD: ctl.cmd = CMD_POP;
            REQ_REMOVE_ID:   ctl.cmd = CMD_REMOVE;
            default:         ctl.cmd = CMD_HOLD;
         endcase
      end
   end

   assign hit[0] = 1'b0;

   // the slot chain, slot 0 at the front
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      logic                 l_keep, l_valid, r_valid;
      logic [ID_BITS-1:0]   l_id, r_id;
      logic [PRIO_BITS-1:0] l_prio, r_prio;

      if (k == 0) begin : g_front
         assign l_keep  = 1'b1;
         assign l_valid = 1'b0;
         assign l_id    = '0;
         assign l_prio  = '0;
      end else begin : g_inner_l
         assign l_keep  = cell_keep[k-1];
         assign l_valid = cell_valid[k-1];
         assign l_id    = cell_id[k-1];
         assign l_prio  = cell_prio[k-1];
      end

      if (k == QUEUE_DEPTH-1) begin : g_back
         assign r_valid = 1'b0;
         assign r_id    = '0;
         assign r_prio  = '0;
      end else begin : g_inner_r
         assign r_valid = cell_valid[k+1];
         assign r_id    = cell_id[k+1];
         assign r_prio  = cell_prio[k+1];
      end

      ppq_cell #(
         .PRIO_BITS(PRIO_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_prio   (new_prio),
         .left_keep  (l_keep),
         .left_valid (l_valid),
         .left_id    (l_id),
         .left_prio  (l_prio),
         .right_valid(r_valid),
         .right_id   (r_id),
         .right_prio (r_prio),
         .hit_in     (hit[k]),
         .valid      (cell_valid[k]),
         .id         (cell_id[k]),
         .prio       (cell_prio[k]),
         .keep       (cell_keep[k]),
         .match      (cell_match[k]),
         .hit_out    (hit[k+1])
      );
   end

   // pick the frontmost matching entry
   always_comb begin
      found_id   = '0;
      found_prio = '0;
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (cell_match[k] && !hit[k]) begin
            found_id   = found_id | cell_id[k];
            found_prio = found_prio | cell_prio[k];
         end
      end
   end

   // response contents
   always_comb begin
      status_in   = ST_MISS;
      out_id_in   = '0;
      out_prio_in = '0;
      is_empty_in = queue_empty;
      case (req_type)
         REQ_INSERT: begin
            is_empty_in = 1'b0;
            if (queue_full) begin
               status_in = ST_FULL;
            end else begin
               status_in   = ST_OK;
               out_id_in   = req_proc_id;
               out_prio_in = new_prio;
            end
         end
         REQ_REMOVE_HEAD, REQ_PEEK_HEAD: begin
            if (!queue_empty) begin
               status_in   = ST_OK;
               out_id_in   = cell_id[0];
               out_prio_in = cell_prio[0];
               if (req_type == REQ_REMOVE_HEAD) begin
                  is_empty_in = !cell_valid[1];
               end
            end
         end
         REQ_REMOVE_ID: begin
            if (hit[QUEUE_DEPTH]) begin
               status_in   = ST_OK;
               out_id_in   = found_id;
               out_prio_in = found_prio;
               is_empty_in = !cell_valid[1];
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         out_id_ff   <= out_id_in;
         out_prio_ff <= PORT_PRIO_BITS'(out_prio_in);
         is_empty_ff <= is_empty_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_out_id   = out_id_ff;
   assign rsp_out_prio = out_prio_ff;
   assign rsp_is_empty = is_empty_ff;

endmodule

[sv/ppq_checker.sv]
// port-level checks of the priority process queue and their binding
module ppq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic [1:0]                         req_type,
   input logic [ppq_pkg::ID_BITS-1:0]        req_proc_id,
   input logic                               rsp_valid,
   input logic [1:0]                         rsp_status,
   input logic [ppq_pkg::ID_BITS-1:0]        rsp_out_id,
   input logic [ppq_pkg::PORT_PRIO_BITS-1:0] rsp_out_prio,
   input logic                               rsp_is_empty
);
   import ppq_pkg::*;

   // one response per request, in the cycle after it
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid == $past(start && !busy)))
      else $error("response strobe does not follow request");

   // failed requests carry no entry
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_out_id == '0 && rsp_out_prio == '0))
      else $error("failed request returned entry data");

   // full status only answers an insert, and a full queue is not empty
   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> ($past(req_type) == REQ_INSERT && !rsp_is_empty))
      else $error("full status on a non-insert request or with empty flag");

   // a successful insert echoes its id and leaves the queue non-empty
   a_insert_echo: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_type) == REQ_INSERT && rsp_status == ST_OK)
      |-> (rsp_out_id == $past(req_proc_id) && !rsp_is_empty))
      else $error("insert response does not echo the request");

endmodule

bind priority_process_queue_core ppq_checker u_ppq_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_type    (req_type),
   .req_proc_id (req_proc_id),
   .rsp_valid   (rsp_valid),
   .rsp_status  (rsp_status),
   .rsp_out_id  (rsp_out_id),
   .rsp_out_prio(rsp_out_prio),
   .rsp_is_empty(rsp_is_empty)
);
